// ===== src/lai_pkg.sv =====
package lai_pkg;

   typedef enum logic [1:0] {
      MODE_INIT   = 2'd0,
      MODE_SAFE   = 2'd1,
      MODE_UNSAFE = 2'd2,
      MODE_ABORT  = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      CMD_OWN_SAFE   = 3'd0,
      CMD_BC_SAFE    = 3'd1,
      CMD_BC_UNSAFE  = 3'd2,
      CMD_IGNITE     = 3'd3,
      CMD_OPEN_VALVE = 3'd4
   } cmd_type;

   // Host packet codes; 5 to 7 all mean "other".
   localparam logic [2:0] RX_ABORT = 3'd0;
   localparam logic [2:0] RX_ACK   = 3'd1;
   localparam logic [2:0] RX_RESET = 3'd2;
   localparam logic [2:0] RX_DUMP  = 3'd3;
   localparam logic [2:0] RX_FILL  = 3'd4;
   localparam logic [2:0] RX_OTHER = 3'd5;

   // Register indexes (byte address 4*index).
   localparam logic REG_COMMAND_PERIOD = 1'b0;
   localparam logic REG_STATUS_PERIOD  = 1'b1;

   localparam logic [15:0] PERIOD_RESET = 16'd100;

   typedef struct packed {
      logic [15:0] command_period_ms;
      logic [15:0] status_period_ms;
   } periods_type;

   typedef struct packed {
      logic [31:0] now_ms;
      logic        estop_key;
      logic        allow_fill;
      logic        allow_dump;
      logic        arm_igniter;
      logic        arm_valve;
      logic        fire_button;
      logic        valve_button;
      logic        rx_valid;
      logic        rx_is_command;
      logic [2:0]  rx_code;
      logic [7:0]  rx_index;
   } tick_type;

   typedef struct packed {
      mode_type    mode;
      cmd_type     held_command;
      logic        abort_latch;
      logic [2:0]  last_rx_code;
      logic [31:0] command_due_ms;
      logic [31:0] status_due_ms;
      logic [31:0] forward_time_ms;
   } state_type;

   typedef struct packed {
      logic        send_command;
      cmd_type     command_kind;
      logic        forward_rx;
      logic        send_ack;
      logic [7:0]  ack_index;
      logic        send_status;
      mode_type    mode_now;
      logic        abort_flag;
      logic [31:0] last_forward_ms;
   } result_type;

endpackage

// ===== src/lai_csr.sv =====
module lai_csr (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [2:0]           paddr,
   input  logic [31:0]          pwdata,
   output logic [31:0]          prdata,
   output logic                 pready,
   output lai_pkg::periods_type periods
);

   lai_pkg::periods_type periods_ff;
   lai_pkg::periods_type periods_in;
   logic                 wr_en;
   logic                 reg_sel;

   assign pready  = 1'b1;
   assign reg_sel = paddr[2];
   assign wr_en   = psel && penable && pwrite;

   always_comb begin
      periods_in = periods_ff;
      if (wr_en) begin
         unique case (reg_sel)
            lai_pkg::REG_COMMAND_PERIOD: periods_in.command_period_ms = pwdata[15:0];
            lai_pkg::REG_STATUS_PERIOD:  periods_in.status_period_ms  = pwdata[15:0];
            default:                     periods_in = periods_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         periods_ff.command_period_ms <= lai_pkg::PERIOD_RESET;
         periods_ff.status_period_ms  <= lai_pkg::PERIOD_RESET;
      end else begin
         periods_ff <= periods_in;
      end
   end

   always_comb begin
      unique case (reg_sel)
         lai_pkg::REG_COMMAND_PERIOD: prdata = {16'd0, periods_ff.command_period_ms};
         lai_pkg::REG_STATUS_PERIOD:  prdata = {16'd0, periods_ff.status_period_ms};
         default:                     prdata = 32'd0;
      endcase
   end

   assign periods = periods_ff;

endmodule

// ===== src/lai_step.sv =====
module lai_step (
   input  lai_pkg::tick_type    tick,
   input  lai_pkg::state_type   cur,
   input  lai_pkg::periods_type periods,
   output lai_pkg::state_type   nxt,
   output lai_pkg::result_type  res
);

   logic cmd_due;
   logic fwd;
   logic ignite_ok;
   logic valve_ok;

   assign cmd_due   = (cur.command_due_ms <= tick.now_ms) && (cur.mode != lai_pkg::MODE_ABORT);
   assign ignite_ok = tick.fire_button && tick.arm_igniter && !tick.allow_fill
                      && !tick.allow_dump;
   assign valve_ok  = tick.valve_button && tick.arm_valve && !tick.allow_fill
                      && !tick.allow_dump;

   always_comb begin
      nxt           = cur;
      fwd           = 1'b0;
      res.send_ack  = 1'b0;
      res.ack_index = 8'd0;

      // repeat the held command
      if (cmd_due) begin
         nxt.command_due_ms = tick.now_ms + {16'd0, periods.command_period_ms};
      end

      // host packet
      if (tick.rx_valid) begin
         nxt.last_rx_code = tick.rx_code;
         if (tick.rx_is_command) begin
            unique case (tick.rx_code)
               lai_pkg::RX_ABORT: begin
                  fwd             = 1'b1;
                  nxt.abort_latch = 1'b1;
               end
               lai_pkg::RX_ACK: begin
                  fwd           = 1'b1;
                  res.send_ack  = 1'b1;
                  res.ack_index = tick.rx_index;
               end
               lai_pkg::RX_RESET: begin
                  if (tick.estop_key && cur.abort_latch) begin
                     nxt.abort_latch = 1'b0;
                     if (cur.mode == lai_pkg::MODE_ABORT) begin
                        nxt.mode = lai_pkg::MODE_SAFE;
                     end
                     fwd = 1'b1;
                  end
               end
               lai_pkg::RX_DUMP: fwd = tick.estop_key && tick.allow_dump;
               lai_pkg::RX_FILL: fwd = tick.estop_key && tick.allow_fill;
               default:          fwd = 1'b0;
            endcase
            if (fwd) begin
               nxt.forward_time_ms = tick.now_ms;
            end
         end
      end

      // status strobe
      res.send_status = cur.status_due_ms <= tick.now_ms;
      if (res.send_status) begin
         nxt.status_due_ms = tick.now_ms + {16'd0, periods.status_period_ms};
      end

      // arming rules
      unique case (nxt.mode)
         lai_pkg::MODE_INIT: nxt.mode = lai_pkg::MODE_SAFE;
         lai_pkg::MODE_SAFE: begin
            if (tick.estop_key) begin
               nxt.held_command = lai_pkg::CMD_BC_UNSAFE;
               nxt.mode         = lai_pkg::MODE_UNSAFE;
            end
         end
         lai_pkg::MODE_UNSAFE: begin
            priority if (!tick.estop_key) begin
               nxt.held_command = lai_pkg::CMD_BC_SAFE;
               nxt.mode         = lai_pkg::MODE_SAFE;
            end else if (ignite_ok) begin
               nxt.held_command = lai_pkg::CMD_IGNITE;
            end else if (valve_ok) begin
               nxt.held_command = lai_pkg::CMD_OPEN_VALVE;
            end else if (nxt.last_rx_code != lai_pkg::RX_ABORT) begin
               nxt.held_command = lai_pkg::CMD_BC_UNSAFE;
            end else begin
               nxt.held_command = lai_pkg::CMD_BC_SAFE;
               nxt.mode         = lai_pkg::MODE_ABORT;
            end
         end
         default: nxt.mode = nxt.mode;
      endcase

      res.send_command    = cmd_due;
      res.command_kind    = cmd_due ? cur.held_command : nxt.held_command;
      res.forward_rx      = fwd;
      res.mode_now        = nxt.mode;
      res.abort_flag      = nxt.abort_latch;
      res.last_forward_ms = nxt.forward_time_ms;
   end

endmodule

// ===== src/launch_arming_interlock.sv =====
// Launch arming interlock: one tick (time, switch levels, host packet) in, one result out.
// A req transfer loads the input register; the result register then drives rsp_valid.
// One tick per cycle unless a low rsp_ready stalls; a tick depends only on state left by
// the previous tick, which the single-pass step logic updates when the result register loads.
// Reset (synchronous, active high): empties both stages, mode init, periods 100 ms,
// all due times and the forward time zero.
module launch_arming_interlock (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_now_ms,
   input  logic        req_estop_key,
   input  logic        req_allow_fill,
   input  logic        req_allow_dump,
   input  logic        req_arm_igniter,
   input  logic        req_arm_valve,
   input  logic        req_fire_button,
   input  logic        req_valve_button,
   input  logic        req_rx_valid,
   input  logic        req_rx_is_command,
   input  logic [2:0]  req_rx_code,
   input  logic [7:0]  req_rx_index,

   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_send_command,
   output logic [2:0]  rsp_command_kind,
   output logic        rsp_forward_rx,
   output logic        rsp_send_ack,
   output logic [7:0]  rsp_ack_index,
   output logic        rsp_send_status,
   output logic [1:0]  rsp_mode_now,
   output logic        rsp_abort_flag,
   output logic [31:0] rsp_last_forward_ms,

   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   lai_pkg::periods_type periods;

   // input stage
   logic                 tick_valid_ff;
   logic                 tick_valid_in;
   lai_pkg::tick_type    tick_ff;

   // interlock state, updated once per tick as it moves to the result stage
   lai_pkg::state_type   state_ff;
   lai_pkg::state_type   state_in;

   // result stage
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   lai_pkg::result_type  result_ff;
   lai_pkg::result_type  result_in;

   logic                 advance;

   lai_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .periods (periods)
   );

   lai_step u_step (
      .tick    (tick_ff),
      .cur     (state_ff),
      .periods (periods),
      .nxt     (state_in),
      .res     (result_in)
   );

   // Advance the held tick when the result register is empty or being drained.
   assign advance   = tick_valid_ff && (!rsp_valid_ff || rsp_ready);
   // Take a new tick whenever the input stage is empty or emptying this cycle.
   assign req_ready = !tick_valid_ff || advance;

   always_comb begin
      tick_valid_in = tick_valid_ff;
      if (req_valid && req_ready) begin
         tick_valid_in = 1'b1;
      end else if (advance) begin
         tick_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_valid_ff            <= 1'b0;
         rsp_valid_ff             <= 1'b0;
         state_ff.mode            <= lai_pkg::MODE_INIT;
         state_ff.held_command    <= lai_pkg::CMD_OWN_SAFE;
         state_ff.abort_latch     <= 1'b0;
         state_ff.last_rx_code    <= lai_pkg::RX_OTHER;
         state_ff.command_due_ms  <= 32'd0;
         state_ff.status_due_ms   <= 32'd0;
         state_ff.forward_time_ms <= 32'd0;
      end else begin
         tick_valid_ff <= tick_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   // Payload registers: capture on transfer, hold otherwise.
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         tick_ff.now_ms        <= req_now_ms;
         tick_ff.estop_key     <= req_estop_key;
         tick_ff.allow_fill    <= req_allow_fill;
         tick_ff.allow_dump    <= req_allow_dump;
         tick_ff.arm_igniter   <= req_arm_igniter;
         tick_ff.arm_valve     <= req_arm_valve;
         tick_ff.fire_button   <= req_fire_button;
         tick_ff.valve_button  <= req_valve_button;
         tick_ff.rx_valid      <= req_rx_valid;
         tick_ff.rx_is_command <= req_rx_is_command;
         tick_ff.rx_code       <= req_rx_code;
         tick_ff.rx_index      <= req_rx_index;
      end
      if (advance) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_send_command    = result_ff.send_command;
   assign rsp_command_kind    = result_ff.command_kind;
   assign rsp_forward_rx      = result_ff.forward_rx;
   assign rsp_send_ack        = result_ff.send_ack;
   assign rsp_ack_index       = result_ff.ack_index;
   assign rsp_send_status     = result_ff.send_status;
   assign rsp_mode_now        = result_ff.mode_now;
   assign rsp_abort_flag      = result_ff.abort_flag;
   assign rsp_last_forward_ms = result_ff.last_forward_ms;

endmodule

// ===== src/lai_chk.sv =====
module lai_chk (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_send_command,
   input logic [2:0]  rsp_command_kind,
   input logic        rsp_forward_rx,
   input logic        rsp_send_ack,
   input logic [7:0]  rsp_ack_index,
   input logic        rsp_send_status,
   input logic [1:0]  rsp_mode_now,
   input logic        rsp_abort_flag,
   input logic [31:0] rsp_last_forward_ms
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_send_command)
      && $stable(rsp_command_kind) && $stable(rsp_forward_rx) && $stable(rsp_send_ack)
      && $stable(rsp_ack_index) && $stable(rsp_send_status) && $stable(rsp_mode_now)
      && $stable(rsp_abort_flag) && $stable(rsp_last_forward_ms))
      else $error("result changed while stalled");

   a_ack_index_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_send_ack |-> rsp_ack_index == 8'd0)
      else $error("ack index set without ack");

   a_ack_forwards: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_send_ack |-> rsp_forward_rx)
      else $error("ack without forward");

   a_no_init_after_tick: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_mode_now != lai_pkg::MODE_INIT)
      else $error("mode still init after a tick");

endmodule

bind launch_arming_interlock lai_chk u_lai_chk (.*);

// ===== tb/sv/launch_arming_interlock_checker.sv =====
`timescale 1ns / 1ps

module launch_arming_interlock_checker (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [31:0] req_now_ms,
   input  logic        req_estop_key,
   input  logic        req_allow_fill,
   input  logic        req_allow_dump,
   input  logic        req_arm_igniter,
   input  logic        req_arm_valve,
   input  logic        req_fire_button,
   input  logic        req_valve_button,
   input  logic        req_rx_valid,
   input  logic        req_rx_is_command,
   input  logic [2:0]  req_rx_code,
   input  logic [7:0]  req_rx_index,

   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic        rsp_send_command,
   input  logic [2:0]  rsp_command_kind,
   input  logic        rsp_forward_rx,
   input  logic        rsp_send_ack,
   input  logic [7:0]  rsp_ack_index,
   input  logic        rsp_send_status,
   input  logic [1:0]  rsp_mode_now,
   input  logic        rsp_abort_flag,
   input  logic [31:0] rsp_last_forward_ms,

   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   input  logic        csr_pready,

   output int          fail_count,
   output int          pending,
   output int          checked
);

   import lai_pkg::*;

   periods_type periods;
   state_type   interlock;
   result_type  tick_outcomes[$];
   int          errors = 0;
   int          matched = 0;

   // One tick of the interlock: repeat, host packet, status strobe, arming rules.
   function automatic result_type interlock_step(input tick_type t);
      result_type r;
      logic       forwarded;
      r = '0;
      forwarded = 1'b0;

      if (interlock.command_due_ms <= t.now_ms && interlock.mode != MODE_ABORT) begin
         interlock.command_due_ms = t.now_ms + {16'd0, periods.command_period_ms};
         r.send_command = 1'b1;
         r.command_kind = interlock.held_command;
      end

      if (t.rx_valid) begin
         interlock.last_rx_code = t.rx_code;
         if (t.rx_is_command) begin
            case (t.rx_code)
               RX_ABORT: begin
                  forwarded = 1'b1;
                  interlock.abort_latch = 1'b1;
               end
               RX_ACK: begin
                  forwarded = 1'b1;
                  r.send_ack = 1'b1;
                  r.ack_index = t.rx_index;
               end
               RX_RESET: begin
                  if (t.estop_key && interlock.abort_latch) begin
                     interlock.abort_latch = 1'b0;
                     if (interlock.mode == MODE_ABORT)
                        interlock.mode = MODE_SAFE;
                     forwarded = 1'b1;
                  end
               end
               RX_DUMP: forwarded = t.estop_key && t.allow_dump;
               RX_FILL: forwarded = t.estop_key && t.allow_fill;
               default: ;
            endcase
            if (forwarded)
               interlock.forward_time_ms = t.now_ms;
         end
      end
      r.forward_rx = forwarded;

      if (interlock.status_due_ms <= t.now_ms) begin
         r.send_status = 1'b1;
         interlock.status_due_ms = t.now_ms + {16'd0, periods.status_period_ms};
      end

      case (interlock.mode)
         MODE_INIT: interlock.mode = MODE_SAFE;
         MODE_SAFE: begin
            if (t.estop_key) begin
               interlock.held_command = CMD_BC_UNSAFE;
               interlock.mode = MODE_UNSAFE;
            end
         end
         MODE_UNSAFE: begin
            if (!t.estop_key) begin
               interlock.held_command = CMD_BC_SAFE;
               interlock.mode = MODE_SAFE;
            end else if (t.fire_button && t.arm_igniter && !t.allow_fill && !t.allow_dump) begin
               interlock.held_command = CMD_IGNITE;
            end else if (t.valve_button && t.arm_valve && !t.allow_fill && !t.allow_dump) begin
               interlock.held_command = CMD_OPEN_VALVE;
            end else if (interlock.last_rx_code != RX_ABORT) begin
               interlock.held_command = CMD_BC_UNSAFE;
            end else begin
               interlock.held_command = CMD_BC_SAFE;
               interlock.mode = MODE_ABORT;
            end
         end
         default: ;
      endcase

      if (!r.send_command)
         r.command_kind = interlock.held_command;
      r.mode_now = interlock.mode;
      r.abort_flag = interlock.abort_latch;
      r.last_forward_ms = interlock.forward_time_ms;
      return r;
   endfunction

   task automatic check_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         errors++;
         $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      end
   endtask

   always @(posedge clock) begin : observe
      tick_type   t;
      result_type want;
      if (reset) begin
         periods.command_period_ms = PERIOD_RESET;
         periods.status_period_ms = PERIOD_RESET;
         interlock.mode = MODE_INIT;
         interlock.held_command = CMD_OWN_SAFE;
         interlock.abort_latch = 1'b0;
         interlock.last_rx_code = RX_OTHER;
         interlock.command_due_ms = '0;
         interlock.status_due_ms = '0;
         interlock.forward_time_ms = '0;
         tick_outcomes.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            if (csr_paddr[2] == REG_COMMAND_PERIOD)
               periods.command_period_ms = csr_pwdata[15:0];
            else
               periods.status_period_ms = csr_pwdata[15:0];
         end

         if (rsp_valid && rsp_ready) begin
            if (tick_outcomes.size() == 0) begin
               errors++;
               $display("%0t ns: result transfer with no tick awaiting one", $time);
            end else begin
               want = tick_outcomes.pop_front();
               check_field("send_command", want.send_command, rsp_send_command);
               check_field("command_kind", want.command_kind, rsp_command_kind);
               check_field("forward_rx", want.forward_rx, rsp_forward_rx);
               check_field("send_ack", want.send_ack, rsp_send_ack);
               check_field("ack_index", want.ack_index, rsp_ack_index);
               check_field("send_status", want.send_status, rsp_send_status);
               check_field("mode_now", want.mode_now, rsp_mode_now);
               check_field("abort_flag", want.abort_flag, rsp_abort_flag);
               check_field("last_forward_ms", want.last_forward_ms, rsp_last_forward_ms);
               matched++;
            end
         end

         if (req_valid && req_ready) begin
            t.now_ms = req_now_ms;
            t.estop_key = req_estop_key;
            t.allow_fill = req_allow_fill;
            t.allow_dump = req_allow_dump;
            t.arm_igniter = req_arm_igniter;
            t.arm_valve = req_arm_valve;
            t.fire_button = req_fire_button;
            t.valve_button = req_valve_button;
            t.rx_valid = req_rx_valid;
            t.rx_is_command = req_rx_is_command;
            t.rx_code = req_rx_code;
            t.rx_index = req_rx_index;
            tick_outcomes.push_back(interlock_step(t));
         end
      end
      fail_count <= errors;
      pending <= tick_outcomes.size();
      checked <= matched;
   end

endmodule

// ===== tb/sv/launch_arming_interlock_tb.sv =====
`timescale 1ns / 1ps

module launch_arming_interlock_tb;

   import lai_pkg::*;

   // Switch masks for the directed ticks: {key, fill, dump, igniter, valve, fire, valve button}.
   localparam logic [6:0] SW_NONE = 7'b0000000;
   localparam logic [6:0] SW_KEY  = 7'b1000000;
   localparam logic [6:0] SW_FILL = 7'b0100000;
   localparam logic [6:0] SW_DUMP = 7'b0010000;
   localparam logic [6:0] SW_IGN  = 7'b0001000;
   localparam logic [6:0] SW_VLV  = 7'b0000100;
   localparam logic [6:0] SW_FIRE = 7'b0000010;
   localparam logic [6:0] SW_VBTN = 7'b0000001;
   localparam logic [6:0] SW_ALL  = 7'b1111111;

   localparam int PHASES          = 7;
   localparam int TICKS_PER_PHASE = 118;
   localparam int HOLD_AFTER      = 300;   // result transfers before the long hold-off
   localparam int HOLD_CYCLES     = 300;
   // Longest quiet stretch of a correct run is the hold-off.
   localparam int STALL_LIMIT     = 2000;

   // Period settings per random phase, extremes and zero included.
   localparam logic [15:0] COMMAND_PERIODS [PHASES] = '{16'd1, 16'd0, 16'hFFFF, 16'd13,
                                                       16'd2, 16'hFFFF, 16'd1};
   localparam logic [15:0] STATUS_PERIODS  [PHASES] = '{16'd1, 16'd0, 16'hFFFF, 16'd250,
                                                       16'd9, 16'd1, 16'hFFFF};

   logic        clock;
   logic        reset = 1'b1;

   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [31:0] req_now_ms = '0;
   logic        req_estop_key = 1'b0;
   logic        req_allow_fill = 1'b0;
   logic        req_allow_dump = 1'b0;
   logic        req_arm_igniter = 1'b0;
   logic        req_arm_valve = 1'b0;
   logic        req_fire_button = 1'b0;
   logic        req_valve_button = 1'b0;
   logic        req_rx_valid = 1'b0;
   logic        req_rx_is_command = 1'b0;
   logic [2:0]  req_rx_code = RX_OTHER;
   logic [7:0]  req_rx_index = '0;

   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_send_command;
   logic [2:0]  rsp_command_kind;
   logic        rsp_forward_rx;
   logic        rsp_send_ack;
   logic [7:0]  rsp_ack_index;
   logic        rsp_send_status;
   logic [1:0]  rsp_mode_now;
   logic        rsp_abort_flag;
   logic [31:0] rsp_last_forward_ms;

   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   int          fail_count;
   int          pending;
   int          checked;

   bit          steady_flow = 1'b0;   // set: neither side idles
   int          ticks_sent = 0;
   int          directed_ticks = 0;
   int          idle_cycles = 0;
   logic [31:0] timeline = '0;
   logic        key_level = 1'b0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   launch_arming_interlock uut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_now_ms          (req_now_ms),
      .req_estop_key       (req_estop_key),
      .req_allow_fill      (req_allow_fill),
      .req_allow_dump      (req_allow_dump),
      .req_arm_igniter     (req_arm_igniter),
      .req_arm_valve       (req_arm_valve),
      .req_fire_button     (req_fire_button),
      .req_valve_button    (req_valve_button),
      .req_rx_valid        (req_rx_valid),
      .req_rx_is_command   (req_rx_is_command),
      .req_rx_code         (req_rx_code),
      .req_rx_index        (req_rx_index),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_send_command    (rsp_send_command),
      .rsp_command_kind    (rsp_command_kind),
      .rsp_forward_rx      (rsp_forward_rx),
      .rsp_send_ack        (rsp_send_ack),
      .rsp_ack_index       (rsp_ack_index),
      .rsp_send_status     (rsp_send_status),
      .rsp_mode_now        (rsp_mode_now),
      .rsp_abort_flag      (rsp_abort_flag),
      .rsp_last_forward_ms (rsp_last_forward_ms),
      .csr_psel            (csr_psel),
      .csr_penable         (csr_penable),
      .csr_pwrite          (csr_pwrite),
      .csr_paddr           (csr_paddr),
      .csr_pwdata          (csr_pwdata),
      .csr_prdata          (csr_prdata),
      .csr_pready          (csr_pready)
   );

   launch_arming_interlock_checker watch (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_now_ms          (req_now_ms),
      .req_estop_key       (req_estop_key),
      .req_allow_fill      (req_allow_fill),
      .req_allow_dump      (req_allow_dump),
      .req_arm_igniter     (req_arm_igniter),
      .req_arm_valve       (req_arm_valve),
      .req_fire_button     (req_fire_button),
      .req_valve_button    (req_valve_button),
      .req_rx_valid        (req_rx_valid),
      .req_rx_is_command   (req_rx_is_command),
      .req_rx_code         (req_rx_code),
      .req_rx_index        (req_rx_index),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_send_command    (rsp_send_command),
      .rsp_command_kind    (rsp_command_kind),
      .rsp_forward_rx      (rsp_forward_rx),
      .rsp_send_ack        (rsp_send_ack),
      .rsp_ack_index       (rsp_ack_index),
      .rsp_send_status     (rsp_send_status),
      .rsp_mode_now        (rsp_mode_now),
      .rsp_abort_flag      (rsp_abort_flag),
      .rsp_last_forward_ms (rsp_last_forward_ms),
      .csr_psel            (csr_psel),
      .csr_penable         (csr_penable),
      .csr_pwrite          (csr_pwrite),
      .csr_paddr           (csr_paddr),
      .csr_pwdata          (csr_pwdata),
      .csr_pready          (csr_pready),
      .fail_count          (fail_count),
      .pending             (pending),
      .checked             (checked)
   );

   // Watchdog: count cycles in which no transfer happens on any port.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_psel && csr_penable))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles == STALL_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // Result side: draw a stall per result, and hold off once for a long stretch
   // so the block fills up and pushes back on the request side.
   initial begin : result_sink
      int stall;
      int taken;
      bit held;
      taken = 0;
      held = 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         stall = steady_flow ? 0 : $urandom_range(0, 7);
         if (!held && taken >= HOLD_AFTER) begin
            stall = HOLD_CYCLES;
            held = 1'b1;
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         // Advance until a result transfer completes at this edge.
         do @(posedge clock); while (!rsp_valid);
         taken++;
      end
   end

   function automatic tick_type make_tick(input logic [31:0] now, input logic [6:0] sw,
                                          input logic rx, input logic is_cmd,
                                          input logic [2:0] code, input logic [7:0] index);
      tick_type t;
      t.now_ms = now;
      {t.estop_key, t.allow_fill, t.allow_dump, t.arm_igniter,
       t.arm_valve, t.fire_button, t.valve_button} = sw;
      t.rx_valid = rx;
      t.rx_is_command = is_cmd;
      t.rx_code = code;
      t.rx_index = index;
      return t;
   endfunction

   // Random tick: time mostly creeps forward, sometimes jumps, goes back or sits near wrap.
   // The key is sticky so arming sequences get a chance to play out; one in ten ticks is noise.
   function automatic tick_type next_random_tick();
      tick_type    t;
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 70)
         timeline = timeline + $urandom_range(0, 20);
      else if (pick < 90)
         timeline = timeline + $urandom_range(0, 70000);
      else if (pick < 95)
         timeline = $urandom;
      else
         timeline = 32'hFFFF_FFFF - $urandom_range(0, 50);
      if ($urandom_range(0, 7) == 0)
         key_level = ~key_level;

      t.now_ms = timeline;
      t.estop_key = key_level;
      t.allow_fill = ($urandom_range(0, 4) == 0);
      t.allow_dump = ($urandom_range(0, 4) == 0);
      t.arm_igniter = 1'($urandom_range(0, 1));
      t.arm_valve = 1'($urandom_range(0, 1));
      t.fire_button = ($urandom_range(0, 2) == 0);
      t.valve_button = ($urandom_range(0, 2) == 0);
      t.rx_valid = ($urandom_range(0, 99) < 45);
      t.rx_is_command = ($urandom_range(0, 99) < 85);
      pick = $urandom_range(0, 15);
      if (pick < 2)
         t.rx_code = RX_ABORT;
      else if (pick < 5)
         t.rx_code = RX_ACK;
      else if (pick < 8)
         t.rx_code = RX_RESET;
      else if (pick < 10)
         t.rx_code = RX_DUMP;
      else if (pick < 12)
         t.rx_code = RX_FILL;
      else
         t.rx_code = RX_OTHER + 3'($urandom_range(0, 2));
      t.rx_index = 8'($urandom_range(0, 255));

      if ($urandom_range(0, 9) == 0)
         {t.estop_key, t.allow_fill, t.allow_dump, t.arm_igniter, t.arm_valve,
          t.fire_button, t.valve_button, t.rx_valid, t.rx_is_command, t.rx_code} = 12'($urandom);
      return t;
   endfunction

   // Offer one tick; hold valid and payload until the transfer completes.
   task automatic offer_tick(input tick_type t);
      int gap;
      gap = steady_flow ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_now_ms <= t.now_ms;
      req_estop_key <= t.estop_key;
      req_allow_fill <= t.allow_fill;
      req_allow_dump <= t.allow_dump;
      req_arm_igniter <= t.arm_igniter;
      req_arm_valve <= t.arm_valve;
      req_fire_button <= t.fire_button;
      req_valve_button <= t.valve_button;
      req_rx_valid <= t.rx_valid;
      req_rx_is_command <= t.rx_is_command;
      req_rx_code <= t.rx_code;
      req_rx_index <= t.rx_index;
      do @(posedge clock); while (!req_ready);
      ticks_sent++;
   endtask

   // Drop valid and wait until every awaited result is back, plus the pipeline depth.
   task automatic drain;
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (4) @(posedge clock);
   endtask

   // Setup cycle, then access cycle; junk in the upper half checks the 16-bit register.
   task automatic write_period(input logic index, input logic [15:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {index, 2'b00};
      csr_pwdata <= {16'($urandom), value};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic run_directed;
      tick_type seq[$];
      // Reset periods of 100 ms throughout.
      seq.push_back(make_tick(32'd0, SW_NONE, 1'b0, 1'b0, RX_OTHER, 8'h00));        // init to safe
      seq.push_back(make_tick(32'd1, SW_NONE, 1'b1, 1'b0, RX_ABORT, 8'h11));        // not a command
      seq.push_back(make_tick(32'd2, SW_KEY, 1'b0, 1'b0, RX_OTHER, 8'h00));         // arm unsafe
      seq.push_back(make_tick(32'd3, SW_KEY, 1'b1, 1'b1, RX_ACK, 8'hFF));           // ack, top index
      seq.push_back(make_tick(32'd4, SW_KEY | SW_IGN | SW_FIRE, 1'b0, 1'b0, RX_OTHER, 8'h00));
      seq.push_back(make_tick(32'd5, SW_KEY | SW_IGN | SW_FIRE | SW_FILL,
                              1'b1, 1'b1, RX_FILL, 8'h01));                          // fill blocks fire
      seq.push_back(make_tick(32'd6, SW_KEY | SW_VLV | SW_VBTN, 1'b1, 1'b1, RX_DUMP, 8'h02));
      seq.push_back(make_tick(32'd7, SW_KEY | SW_DUMP | SW_VLV | SW_VBTN,
                              1'b1, 1'b1, RX_DUMP, 8'h03));
      seq.push_back(make_tick(32'd8, SW_KEY, 1'b1, 1'b1, RX_RESET, 8'h04));         // no latch yet
      seq.push_back(make_tick(32'd9, SW_KEY, 1'b1, 1'b1, RX_OTHER + 3'd1, 8'h05));
      seq.push_back(make_tick(32'd10, SW_KEY, 1'b1, 1'b1, RX_OTHER + 3'd2, 8'h06));
      seq.push_back(make_tick(32'd11, SW_KEY, 1'b1, 1'b1, RX_FILL, 8'h07));         // fill switch off
      seq.push_back(make_tick(32'd12, SW_KEY, 1'b1, 1'b1, RX_ABORT, 8'h5A));        // into abort
      seq.push_back(make_tick(32'd150, SW_KEY | SW_IGN | SW_FIRE, 1'b0, 1'b0, RX_OTHER, 8'h00));
      seq.push_back(make_tick(32'd151, SW_NONE, 1'b1, 1'b1, RX_RESET, 8'h08));      // key off
      seq.push_back(make_tick(32'd152, SW_KEY, 1'b1, 1'b1, RX_RESET, 8'h09));       // leave abort
      seq.push_back(make_tick(32'd153, SW_KEY, 1'b0, 1'b0, RX_OTHER, 8'h00));
      seq.push_back(make_tick(32'd154, SW_NONE, 1'b0, 1'b0, RX_OTHER, 8'h00));      // disarm
      seq.push_back(make_tick(32'hFFFF_FFF0, SW_ALL, 1'b1, 1'b1, RX_ACK, 8'h00));
      seq.push_back(make_tick(32'hFFFF_FFFF, SW_KEY, 1'b1, 1'b1, RX_ACK, 8'hAA));   // due wrapped
      seq.push_back(make_tick(32'd3, SW_KEY, 1'b0, 1'b0, RX_OTHER, 8'h00));         // time wrapped
      seq.push_back(make_tick(32'h8000_0000, SW_KEY, 1'b1, 1'b0, RX_RESET, 8'h7F));
      foreach (seq[i])
         offer_tick(seq[i]);
      directed_ticks = seq.size();
   endtask

   initial begin : stimulus
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      run_directed();
      drain();

      // Random phases, each under its own pair of periods; two of them run with no gaps or stalls.
      for (int p = 0; p < PHASES; p++) begin
         write_period(REG_COMMAND_PERIOD, COMMAND_PERIODS[p]);
         write_period(REG_STATUS_PERIOD, STATUS_PERIODS[p]);
         steady_flow = (p == 3) || (p == 6);
         repeat (TICKS_PER_PHASE)
            offer_tick(next_random_tick());
         drain();
      end
      repeat (10) @(posedge clock);

      $display("Covered %0d ticks (%0d directed) over %0d period settings, zero and 65535 ms",
               ticks_sent, directed_ticks, PHASES + 1);
      $display("included; %0d results checked, one long result-side hold-off applied.", checked);
      if (fail_count == 0 && pending == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
